[sv/prb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_pkg
// Shared widths, codes and types of the timestamp reorder buffer.
// ----------------------------------------------------------------------------
package prb_pkg;

  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 32;
  localparam int PTS_W       = 64;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // request codes on the input channel
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_EMPTY  = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;
  localparam logic [1:0] REQ_DROP   = 2'd3;

  // operations queued for the back end
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FLUSH  = 2'd1;
  localparam logic [1:0] OP_DROP   = 2'd2;

  // result kinds
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [PTS_W-1:0]      pts;
    logic [HANDLE_BITS-1:0]       handle;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/prb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_if
// Valid/ready channels of the reorder buffer: request in, result out.
// ----------------------------------------------------------------------------
interface prb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            req_type;
  logic signed [prb_pkg::PTS_W-1:0]      in_pts;
  logic [prb_pkg::HANDLE_BITS-1:0]       frame_handle;

  modport source (output valid, req_type, in_pts, frame_handle, input ready);
  modport sink   (input valid, req_type, in_pts, frame_handle, output ready);
endinterface

interface prb_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic signed [prb_pkg::PTS_W-1:0]      out_pts;
  logic [prb_pkg::HANDLE_BITS-1:0]       out_handle;
  logic                                  last;

  modport source (output valid, kind, out_pts, out_handle, last, input ready);
  modport sink   (input valid, kind, out_pts, out_handle, last, output ready);
endinterface

[sv/prb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_front
// Accepts request items and turns them into queued operations.
// ----------------------------------------------------------------------------
module prb_front (
  prb_in_if.sink             in_ch,
  input  prb_pkg::q_status_t q_status,
  output logic               push,
  output prb_pkg::cmd_t      cmd
);

  assign in_ch.ready = !q_status.full;

  // empty decode results change nothing and are not queued
  assign push = in_ch.valid && !q_status.full && (in_ch.req_type != prb_pkg::REQ_EMPTY);

  always_comb begin
    cmd.pts    = in_ch.in_pts;
    cmd.handle = in_ch.frame_handle;
    case (in_ch.req_type)
      prb_pkg::REQ_INSERT: cmd.op = prb_pkg::OP_INSERT;
      prb_pkg::REQ_FLUSH:  cmd.op = prb_pkg::OP_FLUSH;
      prb_pkg::REQ_DROP:   cmd.op = prb_pkg::OP_DROP;
      default:             cmd.op = prb_pkg::OP_DROP;
    endcase
  end

endmodule

[sv/prb_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_cmd_queue
// Two-entry queue of operations between the front and back ends.
// ----------------------------------------------------------------------------
module prb_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  prb_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output prb_pkg::cmd_t      head_cmd,
  output prb_pkg::q_status_t q_status
);

  prb_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_status.full  = (cnt_r == 2'd2);
  assign q_status.empty = (cnt_r == 2'd0);
  assign head_cmd       = q_r[rd_ptr_r];

  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/prb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_back
// Sorted frame store and the sequencer that emits, inserts, flushes and drops.
// ----------------------------------------------------------------------------
module prb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  prb_pkg::cmd_t      head_cmd,
  input  prb_pkg::q_status_t q_status,
  output logic               pop,
  prb_out_if.source          out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INS   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [prb_pkg::CNT_W-1:0] CNT_ONE   = prb_pkg::CNT_W'(1);
  localparam logic [prb_pkg::CNT_W-1:0] CNT_TWO   = prb_pkg::CNT_W'(2);
  localparam logic [prb_pkg::CNT_W-1:0] CNT_THREE = prb_pkg::CNT_W'(3);
  localparam logic [prb_pkg::CNT_W-1:0] CNT_FULL  = prb_pkg::CNT_W'(prb_pkg::DEPTH);

  logic [1:0]                              state_r, state_nxt;
  logic [prb_pkg::CNT_W-1:0]               count_r, count_nxt;
  logic signed [prb_pkg::PTS_W-1:0]        cur_pts_r, cur_pts_nxt;
  logic [prb_pkg::HANDLE_BITS-1:0]         cur_handle_r, cur_handle_nxt;
  logic signed [prb_pkg::PTS_W-1:0]        entry_pts_r [prb_pkg::DEPTH];
  logic [prb_pkg::HANDLE_BITS-1:0]         entry_handle_r [prb_pkg::DEPTH];
  logic signed [prb_pkg::PTS_W-1:0]        entry_pts_nxt [prb_pkg::DEPTH];
  logic [prb_pkg::HANDLE_BITS-1:0]         entry_handle_nxt [prb_pkg::DEPTH];
  logic signed [prb_pkg::PTS_W-1:0]        shl_pts [prb_pkg::DEPTH];
  logic [prb_pkg::HANDLE_BITS-1:0]         shl_handle [prb_pkg::DEPTH];

  logic                                    ov_r, ov_nxt;
  logic                                    okind_r, okind_nxt;
  logic signed [prb_pkg::PTS_W-1:0]        opts_r, opts_nxt;
  logic [prb_pkg::HANDLE_BITS-1:0]         ohandle_r, ohandle_nxt;
  logic                                    olast_r, olast_nxt;

  logic                                    can_emit;
  logic                                    head_le, second_le, third_le;
  logic                                    pos_one;

  assign out_ch.valid      = ov_r;
  assign out_ch.kind       = okind_r;
  assign out_ch.out_pts    = opts_r;
  assign out_ch.out_handle = ohandle_r;
  assign out_ch.last       = olast_r;

  assign can_emit  = !ov_r || out_ch.ready;
  assign head_le   = (count_r >= CNT_ONE) && (entry_pts_r[0] <= cur_pts_r);
  assign second_le = (count_r >= CNT_TWO) && (entry_pts_r[1] <= cur_pts_r);
  assign third_le  = (count_r >= CNT_THREE) && (shl_pts[1] <= cur_pts_r);
  assign pos_one   = head_le;

  // store moved one place toward the head
  always_comb begin
    for (int i = 0; i < prb_pkg::DEPTH - 1; i++) begin
      shl_pts[i]    = entry_pts_r[i+1];
      shl_handle[i] = entry_handle_r[i+1];
    end
    shl_pts[prb_pkg::DEPTH-1]    = entry_pts_r[prb_pkg::DEPTH-1];
    shl_handle[prb_pkg::DEPTH-1] = entry_handle_r[prb_pkg::DEPTH-1];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_pts_nxt    = cur_pts_r;
    cur_handle_nxt = cur_handle_r;
    entry_pts_nxt    = entry_pts_r;
    entry_handle_nxt = entry_handle_r;
    ov_nxt         = ov_r && !out_ch.ready;
    okind_nxt      = okind_r;
    opts_nxt       = opts_r;
    ohandle_nxt    = ohandle_r;
    olast_nxt      = olast_r;
    pop            = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          case (head_cmd.op)
            prb_pkg::OP_INSERT: begin
              cur_pts_nxt    = head_cmd.pts;
              cur_handle_nxt = head_cmd.handle;
              state_nxt      = ST_INS;
            end
            prb_pkg::OP_FLUSH: state_nxt = ST_FLUSH;
            prb_pkg::OP_DROP:  count_nxt = '0;
            default:           count_nxt = '0;
          endcase
        end
      end

      ST_INS: begin
        if (can_emit) begin
          if (second_le) begin
            // head leaves, the next entry is still not after the new frame
            ov_nxt           = 1'b1;
            okind_nxt        = prb_pkg::KIND_FRAME;
            opts_nxt         = entry_pts_r[0];
            ohandle_nxt      = entry_handle_r[0];
            olast_nxt        = !third_le;
            entry_pts_nxt    = shl_pts;
            entry_handle_nxt = shl_handle;
            count_nxt        = count_r - CNT_ONE;
          end else if (count_r == CNT_FULL) begin
            ov_nxt      = 1'b1;
            okind_nxt   = prb_pkg::KIND_REJECT;
            opts_nxt    = cur_pts_r;
            ohandle_nxt = cur_handle_r;
            olast_nxt   = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            // place new frame at head or right after it
            if (!pos_one) begin
              entry_pts_nxt[0]    = cur_pts_r;
              entry_handle_nxt[0] = cur_handle_r;
            end
            for (int i = 1; i < prb_pkg::DEPTH; i++) begin
              if (pos_one && (i == 1)) begin
                entry_pts_nxt[i]    = cur_pts_r;
                entry_handle_nxt[i] = cur_handle_r;
              end else begin
                entry_pts_nxt[i]    = entry_pts_r[i-1];
                entry_handle_nxt[i] = entry_handle_r[i-1];
              end
            end
            count_nxt = count_r + CNT_ONE;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        if (count_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (can_emit) begin
          ov_nxt           = 1'b1;
          okind_nxt        = prb_pkg::KIND_FRAME;
          opts_nxt         = entry_pts_r[0];
          ohandle_nxt      = entry_handle_r[0];
          olast_nxt        = (count_r == CNT_ONE);
          entry_pts_nxt    = shl_pts;
          entry_handle_nxt = shl_handle;
          count_nxt        = count_r - CNT_ONE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_pts_r      <= cur_pts_nxt;
    cur_handle_r   <= cur_handle_nxt;
    entry_pts_r    <= entry_pts_nxt;
    entry_handle_r <= entry_handle_nxt;
    okind_r        <= okind_nxt;
    opts_r         <= opts_nxt;
    ohandle_r      <= ohandle_nxt;
    olast_r        <= olast_nxt;
  end

endmodule

[sv/pts_reorder_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_reorder_buffer
// Keeps decoded frames sorted by timestamp and releases them in display order.
//
//   channel   dir   handshake            payload
//   in_ch     in    valid/ready          req_type, in_pts, frame_handle
//   out_ch    out   valid/ready          kind, out_pts, out_handle, last
//
// An insert leaves the queue, emits stored frames from the head while the next
// entry is not after the new frame, then places or rejects it; a flush emits
// every stored frame in order. The store sequencer handles one operation at a
// time, and a two-entry queue takes further items meanwhile. Empty decode results
// are not queued. A held result stalls the sequencer. Reset empties the store.
// ----------------------------------------------------------------------------
module pts_reorder_buffer (
  input  logic      clk,
  input  logic      rst_n,
  prb_in_if.sink    in_ch,
  prb_out_if.source out_ch
);

  prb_pkg::cmd_t      push_cmd;
  prb_pkg::cmd_t      head_cmd;
  prb_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  prb_front u_front (
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  prb_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  prb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timestamp reorder buffer. Request items are
// driven over valid/ready from a queue, and a software copy of the sorted
// store predicts the released, rejected and flushed frames. Each result is
// checked in order against that prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 40;
  localparam logic signed [prb_pkg::PTS_W-1:0] PTS_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [prb_pkg::PTS_W-1:0] PTS_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [1:0]                       req;
    logic signed [prb_pkg::PTS_W-1:0] pts;
    logic [prb_pkg::HANDLE_BITS-1:0]  handle;
    bit                               drain_first;
  } frame_req_t;

  typedef struct {
    logic                             kind;
    logic signed [prb_pkg::PTS_W-1:0] pts;
    logic [prb_pkg::HANDLE_BITS-1:0]  handle;
    logic                             last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  prb_in_if  in_ch ();
  prb_out_if out_ch ();

  pts_reorder_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  frame_req_t    pending_reqs[$];
  frame_req_t    cur_req;
  frame_result_t expected_results[$];

  logic signed [prb_pkg::PTS_W-1:0] store_pts    [prb_pkg::DEPTH];
  logic [prb_pkg::HANDLE_BITS-1:0]  store_handle [prb_pkg::DEPTH];
  int store_count = 0;

  int offered_cnt    = 0;
  int accepted_cnt   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;
  int errors         = 0;
  longint ts_base    = -100;

  function automatic void expect_frame(logic kind, logic signed [prb_pkg::PTS_W-1:0] pts,
                                       logic [prb_pkg::HANDLE_BITS-1:0] handle);
    frame_result_t res;
    res.kind   = kind;
    res.pts    = pts;
    res.handle = handle;
    res.last   = 1'b0;
    expected_results.push_back(res);
  endfunction

  // sorted store update and the results one request releases
  function automatic void predict_release(frame_req_t r);
    int k;
    int m;
    int pos;
    int i;
    int n0;
    n0 = expected_results.size();
    case (r.req)
      prb_pkg::REQ_INSERT: begin
        k = 0;
        while (k < store_count && store_pts[k] <= r.pts) k++;
        m = (k > 0) ? k - 1 : 0;
        for (i = 0; i < m; i++)
          expect_frame(prb_pkg::KIND_FRAME, store_pts[i], store_handle[i]);
        for (i = m; i < store_count; i++) begin
          store_pts[i - m]    = store_pts[i];
          store_handle[i - m] = store_handle[i];
        end
        store_count -= m;
        pos = (k > 0) ? 1 : 0;
        if (store_count >= prb_pkg::DEPTH) begin
          expect_frame(prb_pkg::KIND_REJECT, r.pts, r.handle);
        end else begin
          for (i = store_count; i > pos; i--) begin
            store_pts[i]    = store_pts[i - 1];
            store_handle[i] = store_handle[i - 1];
          end
          store_pts[pos]    = r.pts;
          store_handle[pos] = r.handle;
          store_count++;
        end
      end
      prb_pkg::REQ_FLUSH: begin
        for (i = 0; i < store_count; i++)
          expect_frame(prb_pkg::KIND_FRAME, store_pts[i], store_handle[i]);
        store_count = 0;
      end
      prb_pkg::REQ_DROP: begin
        store_count = 0;
      end
      default: ;
    endcase
    if (expected_results.size() > n0)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst_n && offered_cnt == accepted_cnt) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
          (!pending_reqs[0].drain_first || expected_results.size() == 0)) begin
        cur_req = pending_reqs.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.req_type     <= cur_req.req;
        in_ch.in_pts       <= cur_req.pts;
        in_ch.frame_handle <= cur_req.handle;
        offered_cnt++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and one long hold
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_left = LONG_HOLD;
      hold_ack  = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: results checked first, then the accepted request predicted
  always @(posedge clk) begin
    frame_result_t exp_res;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d pts=%0d handle=%h last=%0d",
                   $realtime, out_ch.kind, out_ch.out_pts, out_ch.out_handle, out_ch.last);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.kind !== exp_res.kind) begin
            $display("%0t: kind expected %0d got %0d", $realtime, exp_res.kind, out_ch.kind);
            errors++;
          end
          if (out_ch.out_pts !== exp_res.pts) begin
            $display("%0t: pts expected %0d got %0d", $realtime, exp_res.pts, out_ch.out_pts);
            errors++;
          end
          if (out_ch.out_handle !== exp_res.handle) begin
            $display("%0t: handle expected %h got %h", $realtime, exp_res.handle,
                     out_ch.out_handle);
            errors++;
          end
          if (out_ch.last !== exp_res.last) begin
            $display("%0t: last expected %0d got %0d", $realtime, exp_res.last, out_ch.last);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_release(cur_req);
        accepted_cnt++;
      end
    end
  end

  task automatic add_req(logic [1:0] req, logic signed [prb_pkg::PTS_W-1:0] pts,
                         logic [prb_pkg::HANDLE_BITS-1:0] handle, bit drain_first = 1'b0);
    frame_req_t r;
    r.req         = req;
    r.pts         = pts;
    r.handle      = handle;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_sent();
    while (pending_reqs.size() != 0 || offered_cnt != accepted_cnt) @(negedge clk);
  endtask

  // mostly decode-order groups and descending runs, some noise
  task automatic queue_random_traffic(int n_items, bit drain_first);
    int made;
    int sel;
    int len;
    int j;
    longint p;
    made = 0;
    while (made < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        len = $urandom_range(2, 8);
        for (j = 0; j < len; j++) begin
          add_req(prb_pkg::REQ_INSERT, ts_base + $urandom_range(0, 6), $urandom(),
                  drain_first || ($urandom_range(0, 99) < 3));
          drain_first = 1'b0;
          made++;
        end
        ts_base += $urandom_range(0, 8);
      end else if (sel < 65) begin
        len = $urandom_range(8, 20);
        p   = ts_base + 40 + $urandom_range(0, 20);
        for (j = 0; j < len; j++) begin
          add_req(prb_pkg::REQ_INSERT, p, $urandom(), drain_first);
          drain_first = 1'b0;
          p -= $urandom_range(0, 3);
          made++;
        end
        ts_base += 70;
      end else if (sel < 75) begin
        len = $urandom_range(1, 3);
        for (j = 0; j < len; j++) begin
          add_req(prb_pkg::REQ_INSERT, {$urandom(), $urandom()}, $urandom(), drain_first);
          drain_first = 1'b0;
          made++;
        end
      end else if (sel < 85) begin
        add_req(prb_pkg::REQ_FLUSH, {$urandom(), $urandom()}, $urandom());
        made++;
      end else if (sel < 91) begin
        add_req(prb_pkg::REQ_DROP, {$urandom(), $urandom()}, $urandom());
        made++;
      end else begin
        add_req(prb_pkg::REQ_EMPTY, {$urandom(), $urandom()}, $urandom());
        made++;
      end
    end
  endtask

  initial begin
    #3_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int i;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = prb_pkg::REQ_EMPTY;
    in_ch.in_pts       = '0;
    in_ch.frame_handle = '0;
    out_ch.ready       = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: fill with descending stamps, overflow, release, ties, drop, flush
    add_req(prb_pkg::REQ_EMPTY, PTS_MAX, '1);
    for (i = 0; i < prb_pkg::DEPTH; i++) begin
      if (i == 0)
        add_req(prb_pkg::REQ_INSERT, PTS_MAX, '1);
      else if (i == prb_pkg::DEPTH - 1)
        add_req(prb_pkg::REQ_INSERT, PTS_MIN, '0);
      else
        add_req(prb_pkg::REQ_INSERT, longint'(7 - i) * 1000, $urandom());
    end
    add_req(prb_pkg::REQ_INSERT, PTS_MIN, 32'h0000_0000);
    add_req(prb_pkg::REQ_INSERT, 64'sd6500, 32'ha5a5_a5a5);
    add_req(prb_pkg::REQ_INSERT, PTS_MAX, 32'h5a5a_5a5a);
    add_req(prb_pkg::REQ_FLUSH, '0, '0);
    add_req(prb_pkg::REQ_INSERT, 64'sd0, 32'h0000_0001);
    add_req(prb_pkg::REQ_INSERT, 64'sd0, 32'h0000_0002);
    add_req(prb_pkg::REQ_DROP, '0, '0);
    add_req(prb_pkg::REQ_DROP, '1, '1);
    add_req(prb_pkg::REQ_FLUSH, '1, '1);
    wait_sent();

    // no idling, with the sink held off long enough to back up the input
    queue_random_traffic(32, 1'b0);
    hold_req++;
    wait_sent();

    // sender idle, first waiting for all results to come back
    send_idle_pct = 65;
    queue_random_traffic(28, 1'b1);
    wait_sent();

    // receiver stalling
    send_idle_pct  = 0;
    recv_stall_pct = 65;
    queue_random_traffic(32, 1'b0);
    wait_sent();

    // both
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    queue_random_traffic(28, 1'b0);
    wait_sent();

    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

[pts_reorder_buffer.f]
sv/prb_pkg.sv
sv/prb_if.sv
sv/prb_front.sv
sv/prb_cmd_queue.sv
sv/prb_back.sv
sv/pts_reorder_buffer.sv
verif/tb.sv
